[rtl/mexp_pkg.sv]
// Shared types and constants for the modular exponentiation block.
// Used by the controller, the datapath, the multiplier unit and the top level.
// No dependencies.
package mexp_pkg;

  // Fixed port widths of the data and configuration channels.
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 1;

  // Default operand width inside the block.
  localparam int WIDTH_DEF = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

  // Operation requested from the modular multiplier.
  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,
    OP_MUL    = 2'd1,
    OP_SQR    = 2'd2
  } mm_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_GO,
    S_RED_WAIT,
    S_CHECK,
    S_MUL_GO,
    S_MUL_WAIT,
    S_SQR_GO,
    S_SQR_WAIT,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load;
    logic   mm_start;
    mm_op_t mm_op;
    logic   wb_sq;
    logic   wb_acc;
    logic   shift_exp;
    logic   out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mm_done;
    logic e_bit;
    logic e_zero;
    logic out_free;
  } ctrl_sts_t;

endpackage

[rtl/modular_exponentiation.sv]
// Modular exponentiation block, top level: power_result = base_value ^ exponent mod modulus.
// Depends on mexp_pkg; instantiates mexp_ctrl and mexp_dp (which holds mexp_mulmod).
//
// Load modulus (index 0) and exponent (index 1) through the cfg port, then stream base values.
// Exponent bits are scanned from the least significant end with square-and-multiply, all
// products reduced by one shared bit-serial modular multiplier. An item runs a reduction of
// the base, then for each exponent bit up to the highest set one a multiplication if the bit
// is set and a squaring; the finished item then waits while a stalled output register is
// still full. One item is worked on at a time; a finished result waits in an output
// register while the next item is taken. A zero modulus makes all arithmetic wrap modulo
// 2^WIDTH; exponent zero always gives 1.
module modular_exponentiation #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mexp_pkg::DATA_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mexp_pkg::DATA_W-1:0]    in_base_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mexp_pkg::DATA_W-1:0]    out_power_result
);
  import mexp_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mexp_dp #(.W(WIDTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_base_value    (in_base_value),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_power_result (out_power_result),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

[rtl/mexp_mulmod.sv]
// Iterative modular multiplier: computes a * b mod m, one multiplier bit per cycle.
// Depends on mexp_pkg. Requires a <= m; a zero modulus means modulo 2^W.
module mexp_mulmod #(
  parameter int W = mexp_pkg::WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] op_a,
  input  logic [W-1:0] op_b,
  input  logic [W-1:0] modulus,
  output logic         done,
  output logic [W-1:0] result
);
  import mexp_pkg::*;

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     a_r, a_nxt;
  logic [W-1:0]     b_r, b_nxt;
  logic [W-1:0]     m_r, m_nxt;
  logic             mz_r, mz_nxt;
  logic [W-1:0]     acc_r, acc_nxt;

  logic [W+1:0]     sum;
  logic [W+1:0]     m_ext;
  logic [W+1:0]     m2_ext;
  logic [W+2:0]     diff1;
  logic [W+2:0]     diff2;
  logic [W-1:0]     step_val;

  // Interleaved reduction: sum = 2r + bit*a stays below 3m, so at most 2m is removed.
  always_comb begin
    sum    = (W+2)'({acc_r, 1'b0}) + (b_r[W-1] ? (W+2)'(a_r) : '0);
    m_ext  = (W+2)'(m_r);
    m2_ext = (W+2)'({m_r, 1'b0});
    diff1  = {1'b0, sum} - {1'b0, m_ext};
    diff2  = {1'b0, sum} - {1'b0, m2_ext};
    if (mz_r) begin
      step_val = sum[W-1:0];
    end else if (!diff2[W+2]) begin
      step_val = diff2[W-1:0];
    end else if (!diff1[W+2]) begin
      step_val = diff1[W-1:0];
    end else begin
      step_val = sum[W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    mz_nxt   = mz_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(W - 1);
      a_nxt    = op_a;
      b_nxt    = op_b;
      m_nxt    = modulus;
      mz_nxt   = (modulus == '0);
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = step_val;
      b_nxt   = {b_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    mz_r  <= mz_nxt;
    acc_r <= acc_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("multiplier started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("multiplier done held longer than one cycle");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == '0) |=> (done_r && !busy_r))
    else $error("multiplier did not finish after its last step");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("multiplier done while still busy");
`endif

endmodule

[rtl/mexp_dp.sv]
// Datapath: configuration registers, base/result/exponent registers, output register.
// Depends on mexp_pkg and instantiates mexp_mulmod.
module mexp_dp #(
  parameter int W = mexp_pkg::WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mexp_pkg::DATA_W-1:0]     cfg_data,
  input  logic [mexp_pkg::DATA_W-1:0]     in_base_value,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [mexp_pkg::DATA_W-1:0]     out_power_result,
  input  mexp_pkg::ctrl_cmd_t             cmd,
  output mexp_pkg::ctrl_sts_t             sts
);
  import mexp_pkg::*;

  logic [W-1:0] mod_r, mod_nxt;
  logic [W-1:0] exp_r, exp_nxt;
  logic [W-1:0] base_r, base_nxt;
  logic [W-1:0] sq_r, sq_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] esh_r, esh_nxt;
  logic         ov_r, ov_nxt;
  logic [W-1:0] od_r, od_nxt;

  logic [W-1:0] mm_a;
  logic [W-1:0] mm_b;
  logic         mm_done;
  logic [W-1:0] mm_res;

  always_comb begin
    case (cmd.mm_op)
      OP_REDUCE: begin
        mm_a = W'(1);
        mm_b = base_r;
      end
      OP_MUL: begin
        mm_a = sq_r;
        mm_b = acc_r;
      end
      OP_SQR: begin
        mm_a = sq_r;
        mm_b = sq_r;
      end
      default: begin
        mm_a = '0;
        mm_b = '0;
      end
    endcase
  end

  mexp_mulmod #(.W(W)) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mm_start),
    .op_a    (mm_a),
    .op_b    (mm_b),
    .modulus (mod_r),
    .done    (mm_done),
    .result  (mm_res)
  );

  always_comb begin
    mod_nxt = mod_r;
    exp_nxt = exp_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:  mod_nxt = cfg_data[W-1:0];
        REG_EXPONENT: exp_nxt = cfg_data[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    base_nxt = base_r;
    sq_nxt   = sq_r;
    acc_nxt  = acc_r;
    esh_nxt  = esh_r;
    if (cmd.load) begin
      base_nxt = in_base_value[W-1:0];
      acc_nxt  = W'(1);
      esh_nxt  = exp_r;
    end
    if (cmd.wb_sq) begin
      sq_nxt = mm_res;
    end
    if (cmd.wb_acc) begin
      acc_nxt = mm_res;
    end
    if (cmd.shift_exp) begin
      esh_nxt = esh_r >> 1;
    end
  end

  // The output register frees itself when the downstream side takes the item.
  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      ov_nxt = 1'b1;
      od_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= W'(1);
      exp_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      mod_r <= mod_nxt;
      exp_r <= exp_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    sq_r   <= sq_nxt;
    acc_r  <= acc_nxt;
    esh_r  <= esh_nxt;
    od_r   <= od_nxt;
  end

  always_comb begin
    sts.mm_done  = mm_done;
    sts.e_bit    = esh_r[0];
    sts.e_zero   = (esh_r == '0);
    sts.out_free = !ov_r || !out_stall;
  end

  assign out_valid        = ov_r;
  assign out_power_result = DATA_W'(od_r);

endmodule

[rtl/mexp_ctrl.sv]
// Controller state machine for square-and-multiply sequencing.
// Depends on mexp_pkg; drives the datapath through a command struct.
module mexp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mexp_pkg::ctrl_sts_t  sts,
  output mexp_pkg::ctrl_cmd_t  cmd
);
  import mexp_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_RED_GO;
      S_RED_GO:   state_nxt = S_RED_WAIT;
      S_RED_WAIT: if (sts.mm_done) state_nxt = S_CHECK;
      S_CHECK: begin
        if (sts.e_zero) begin
          state_nxt = S_FINISH;
        end else if (sts.e_bit) begin
          state_nxt = S_MUL_GO;
        end else begin
          state_nxt = S_SQR_GO;
        end
      end
      S_MUL_GO:   state_nxt = S_MUL_WAIT;
      S_MUL_WAIT: if (sts.mm_done) state_nxt = S_SQR_GO;
      S_SQR_GO:   state_nxt = S_SQR_WAIT;
      S_SQR_WAIT: if (sts.mm_done) state_nxt = S_CHECK;
      S_FINISH:   if (sts.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.mm_op = OP_REDUCE;
    unique case (state_r)
      S_IDLE:     cmd.load = in_valid;
      S_RED_GO: begin
        cmd.mm_start = 1'b1;
        cmd.mm_op    = OP_REDUCE;
      end
      S_RED_WAIT: cmd.wb_sq = sts.mm_done;
      S_MUL_GO: begin
        cmd.mm_start = 1'b1;
        cmd.mm_op    = OP_MUL;
      end
      S_MUL_WAIT: cmd.wb_acc = sts.mm_done;
      S_SQR_GO: begin
        cmd.mm_start = 1'b1;
        cmd.mm_op    = OP_SQR;
      end
      S_SQR_WAIT: begin
        cmd.wb_sq     = sts.mm_done;
        cmd.shift_exp = sts.mm_done;
      end
      S_FINISH:   cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_RED_GO))
    else $error("accepted item did not start the base reduction");

  a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && !sts.out_free) |=> (state_r == S_FINISH))
    else $error("result dropped while output register was full");

  a_shift_only_sqr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_exp |-> (state_r == S_SQR_WAIT && sts.mm_done))
    else $error("exponent shifted outside a finished squaring");
`endif

endmodule

[test/modular_exponentiation_test.sv]
// Self-checking testbench for the modular exponentiation block: streams base values
// under several key settings and compares every result with a software power-mod.
// Depends on mexp_pkg and modular_exponentiation.
module modular_exponentiation_test;
  import mexp_pkg::*;

  localparam int OPW         = WIDTH_DEF;
  localparam int TOTAL_ITEMS = 290;
  localparam int QUIET_LIMIT = 30000;

  class power_scoreboard;
    bit [DATA_W-1:0] expected_powers[$];
    bit [63:0]       modulus_reg;
    bit [63:0]       exponent_reg;
    int              mismatches;

    function new();
      modulus_reg  = 64'd1;
      exponent_reg = 64'd0;
      mismatches   = 0;
    endfunction

    function bit [63:0] op_mask();
      return (64'd1 << OPW) - 64'd1;
    endfunction

    // A zero modulus drops the reduction and keeps only the low operand bits.
    function bit [63:0] fold(bit [63:0] v, bit [63:0] m);
      if (m == 64'd0) begin
        return v & op_mask();
      end
      return v % m;
    endfunction

    function bit [DATA_W-1:0] predict_power(bit [DATA_W-1:0] base);
      bit [63:0] acc;
      bit [63:0] sq;
      acc = 64'd1;
      sq  = fold({32'd0, base} & op_mask(), modulus_reg);
      for (int k = 0; k < OPW; k++) begin
        if (exponent_reg[k]) begin
          acc = fold(acc * sq, modulus_reg);
        end
        sq = fold(sq * sq, modulus_reg);
      end
      return acc[DATA_W-1:0];
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      if (idx == REG_MODULUS) begin
        modulus_reg = {32'd0, data} & op_mask();
      end else if (idx == REG_EXPONENT) begin
        exponent_reg = {32'd0, data} & op_mask();
      end
    endfunction

    function void note_base(bit [DATA_W-1:0] base);
      expected_powers.push_back(predict_power(base));
    endfunction

    task report(string what, bit [DATA_W-1:0] got, bit [DATA_W-1:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      mismatches++;
    endtask

    task check_power(bit [DATA_W-1:0] got);
      bit [DATA_W-1:0] want;
      if (expected_powers.size() == 0) begin
        report("result with no item pending", got, '0);
      end else begin
        want = expected_powers.pop_front();
        if (got !== want) begin
          report("power_result", got, want);
        end
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MODULUS;
  logic [DATA_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DATA_W-1:0]    in_base_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    out_power_result;

  power_scoreboard sb = new();
  int items_sent = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 62;
  int quiet_cycles = 0;

  modular_exponentiation #(.WIDTH(OPW)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_base_value    (in_base_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_result (out_power_result)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Register writes, accepted items and results are all seen at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        sb.set_register(cfg_index, cfg_data);
      end
      if (in_valid && !in_stall) begin
        sb.note_base(in_base_value);
      end
      if (out_valid && !out_stall) begin
        sb.check_power(out_power_result);
      end
    end
  end

  always @(posedge clk) begin
    if (cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item was taken.
  task send_base(bit [DATA_W-1:0] base);
    if (items_sent < TOTAL_ITEMS / 3) begin
      send_idle_pct = 9;
      recv_idle_pct = 62;
    end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
      send_idle_pct = 62;
      recv_idle_pct = 9;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_base_value <= base;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.expected_powers.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task set_key(bit [DATA_W-1:0] modulus, bit [DATA_W-1:0] exponent);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MODULUS;
    cfg_data  <= modulus;
    @(negedge clk);
    cfg_index <= REG_EXPONENT;
    cfg_data  <= exponent;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    bit [DATA_W-1:0] cur_mod;
    bit [DATA_W-1:0] cur_exp;
    bit [DATA_W-1:0] base;
    int              batch;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset key: modulus one, exponent zero still gives one.
    send_base(32'h0000_0000);
    send_base(32'hFFFF_FFFF);

    // Largest modulus and exponent: every exponent bit is set.
    set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_base(32'h0000_0000);
    send_base(32'h0000_0001);
    send_base(32'hFFFF_FFFE);
    send_base(32'hFFFF_FFFF);

    // Zero modulus: arithmetic wraps at the operand width.
    set_key(32'h0000_0000, 32'd65537);
    send_base(32'h0000_0003);
    send_base(32'hFFFF_FFFF);
    send_base(32'h1234_5678);

    // Modulus one with a nonzero exponent reduces everything to zero.
    set_key(32'h0000_0001, 32'd5);
    send_base(32'h0000_0007);
    send_base(32'h0000_0000);

    // Textbook RSA key, with bases around the modulus.
    set_key(32'd3233, 32'd17);
    send_base(32'd65);
    send_base(32'd3232);
    send_base(32'd3233);
    send_base(32'd3234);
    send_base(32'd0);

    // Exponent one is a plain reduction of the base.
    set_key(32'h8000_0001, 32'd1);
    send_base(32'hFFFF_FFFF);
    send_base(32'h8000_0001);
    send_base(32'h8000_0000);

    set_key(32'd97, 32'd0);
    send_base(32'd0);
    send_base(32'd96);

    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       cur_mod = $urandom_range(1, 255);
        1:       cur_mod = 32'd1;
        2:       cur_mod = 32'hFFFF_FFFF;
        3:       cur_mod = $urandom_range(2, 65535);
        4:       cur_mod = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        default: cur_mod = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0:       cur_exp = 32'd0;
        1:       cur_exp = 32'd65537;
        2:       cur_exp = 32'd3;
        3:       cur_exp = $urandom;
        4:       cur_exp = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom;
        default: cur_exp = $urandom_range(1, 1023);
      endcase
      set_key(cur_mod, cur_exp);
      batch = $urandom_range(10, 30);
      for (int i = 0; i < batch && items_sent < TOTAL_ITEMS; i++) begin
        case ($urandom_range(0, 9))
          0:       base = 32'h0000_0000;
          1:       base = 32'hFFFF_FFFF;
          2:       base = cur_mod - 32'd1;
          3:       base = (cur_mod != 0) ? ($urandom % cur_mod) : $urandom;
          4:       base = cur_mod;
          default: base = $urandom;
        endcase
        // Hold the sender back once per batch until the block has emptied.
        if (i == batch / 2) begin
          drain();
        end
        send_base(base);
      end
    end

    drain();
    repeat (100) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_powers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[modular_exponentiation.f]
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/mexp_dp.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation.sv
test/modular_exponentiation_test.sv
